FILE: rtl/core/psd_band_classifier_defines.svh
// assertion macros for the band classifier
`ifndef PSD_BAND_CLASSIFIER_DEFINES_SVH
`define PSD_BAND_CLASSIFIER_DEFINES_SVH

// condition holds in the same cycle
`define PSD_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("psd check failed: same cycle");

// condition holds in the following cycle
`define PSD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("psd check failed: next cycle");

`endif

FILE: rtl/core/psd_pkg.sv
`timescale 1ns / 1ps

package psd_pkg;

   localparam int BREAKPOINTS      = 9;
   localparam int ENERGY_FRAC_BITS = 4;
   localparam int ENERGY_WIDTH     = 20;
   localparam int FRACTION_WIDTH   = 16;
   localparam int FRACTION_SHIFT   = 14;
   localparam int REGIONS          = BREAKPOINTS + 1;
   localparam int REGION_WIDTH     = $clog2(REGIONS);
   localparam int SPAN_WIDTH       = ENERGY_WIDTH + 1;
   localparam int EDGE_WIDTH       = 8;
   localparam int DY_WIDTH         = EDGE_WIDTH + 1;
   localparam int FRAC100_WIDTH    = FRACTION_WIDTH + 7;
   localparam int PROD_WIDTH       = 48;

   localparam int CURVES          = 4;
   localparam int CURVE_GAMMA_LO  = 0;
   localparam int CURVE_GAMMA_HI  = 1;
   localparam int CURVE_ALPHA_LO  = 2;
   localparam int CURVE_ALPHA_HI  = 3;

   // breakpoints in whole photoelectrons
   localparam int BP_PE [BREAKPOINTS] = '{0, 100, 200, 300, 500, 5000, 10000, 15000, 25000};

   // band edges in hundredths
   localparam int EDGE_TAB [CURVES][BREAKPOINTS] = '{
      '{ 0,  0,  0,  0,  0, 20, 20, 20, 20},
      '{60, 50, 48, 46, 42, 32, 32, 32, 32},
      '{30, 40, 45, 45, 45, 45, 40, 40, 40},
      '{95, 95, 85, 85, 85, 85, 85, 85, 85}
   };

   typedef logic signed [SPAN_WIDTH-1:0] span_type;
   typedef logic signed [DY_WIDTH-1:0]   dy_type;
   typedef logic signed [PROD_WIDTH-1:0] prod_type;

   typedef struct packed {
      prod_type                    lhs;
      logic [CURVES-1:0][PROD_WIDTH-1:0] rhs;
   } edges_type;

   typedef struct packed {
      logic is_gamma;
      logic is_alpha;
   } class_type;

   function automatic span_type bp_scaled(input int k);
      return SPAN_WIDTH'(BP_PE[k] * (2 ** ENERGY_FRAC_BITS));
   endfunction

   // region 0: clamp low, region BREAKPOINTS: clamp high, else segment r-1
   function automatic logic region_interior(input int r);
      logic ok;
      ok = 1'b0;
      if (r > 0 && r < BREAKPOINTS) begin
         ok = (BP_PE[r] - BP_PE[r-1]) > 0;
      end
      return ok;
   endfunction

   function automatic span_type region_base(input int r);
      span_type base;
      base = '0;
      if (region_interior(r)) begin
         base = bp_scaled(r - 1);
      end
      return base;
   endfunction

   function automatic span_type region_span(input int r);
      span_type span;
      span = SPAN_WIDTH'(1);
      if (region_interior(r)) begin
         span = bp_scaled(r) - bp_scaled(r - 1);
      end
      return span;
   endfunction

   function automatic int region_y0(input int c, input int r);
      int y0;
      if (r == 0) begin
         y0 = EDGE_TAB[c][0];
      end else if (r >= BREAKPOINTS) begin
         y0 = EDGE_TAB[c][BREAKPOINTS-1];
      end else begin
         y0 = EDGE_TAB[c][r-1];
      end
      return y0;
   endfunction

   function automatic dy_type region_dy(input int c, input int r);
      dy_type dy;
      dy = '0;
      if (region_interior(r)) begin
         dy = DY_WIDTH'(EDGE_TAB[c][r] - EDGE_TAB[c][r-1]);
      end
      return dy;
   endfunction

   function automatic prod_type region_y0d(input int c, input int r);
      longint y0d;
      y0d = longint'(region_y0(c, r)) * longint'(region_span(r));
      return PROD_WIDTH'(y0d);
   endfunction

endpackage

FILE: rtl/core/psd_req_if.sv
`timescale 1ns / 1ps

interface psd_req_if;
   logic                                       valid;
   logic                                       ready;
   logic signed [psd_pkg::ENERGY_WIDTH-1:0]    energy;
   logic signed [psd_pkg::FRACTION_WIDTH-1:0]  prompt_fraction;

   modport source (output valid, output energy, output prompt_fraction, input ready);
   modport sink (input valid, input energy, input prompt_fraction, output ready);
endinterface

FILE: rtl/core/psd_rsp_if.sv
`timescale 1ns / 1ps

interface psd_rsp_if;
   logic valid;
   logic ready;
   logic is_gamma;
   logic is_alpha;

   modport source (output valid, output is_gamma, output is_alpha, input ready);
   modport sink (input valid, input is_gamma, input is_alpha, output ready);
endinterface

FILE: rtl/core/psd_interp.sv
`timescale 1ns / 1ps

module psd_interp (
   input  logic signed [psd_pkg::ENERGY_WIDTH-1:0]   energy,
   input  logic signed [psd_pkg::FRACTION_WIDTH-1:0] prompt_fraction,
   output psd_pkg::edges_type                        edges
);

   logic [psd_pkg::REGION_WIDTH-1:0]         region;
   psd_pkg::span_type                        energy_ext;
   psd_pkg::span_type                        offset;
   psd_pkg::span_type                        span;
   logic signed [psd_pkg::FRAC100_WIDTH-1:0] frac_ext;
   logic signed [psd_pkg::FRAC100_WIDTH-1:0] frac100;

   assign energy_ext = psd_pkg::SPAN_WIDTH'(energy);

   // segment search against constant breakpoints
   always_comb begin
      region = psd_pkg::REGION_WIDTH'(psd_pkg::BREAKPOINTS);
      for (int k = psd_pkg::BREAKPOINTS - 1; k >= 1; k--) begin
         if (energy_ext < psd_pkg::bp_scaled(k)) begin
            region = psd_pkg::REGION_WIDTH'(k);
         end
      end
      if (energy_ext <= psd_pkg::bp_scaled(0)) begin
         region = '0;
      end
   end

   assign offset   = energy_ext - psd_pkg::region_base(int'(region));
   assign span     = psd_pkg::region_span(int'(region));
   assign frac_ext = psd_pkg::FRAC100_WIDTH'(prompt_fraction);
   assign frac100  = (frac_ext <<< 6) + (frac_ext <<< 5) + (frac_ext <<< 2);

   // edge scaled by segment width: (y0*d + t*dy) << 14
   always_comb begin
      psd_pkg::prod_type slope_term;
      psd_pkg::prod_type sum;
      edges.lhs = psd_pkg::PROD_WIDTH'(frac100 * span);
      for (int c = 0; c < psd_pkg::CURVES; c++) begin
         slope_term   = psd_pkg::PROD_WIDTH'(offset * psd_pkg::region_dy(c, int'(region)));
         sum          = psd_pkg::region_y0d(c, int'(region)) + slope_term;
         edges.rhs[c] = sum <<< psd_pkg::FRACTION_SHIFT;
      end
   end

endmodule

FILE: rtl/core/psd_band_cmp.sv
`timescale 1ns / 1ps

module psd_band_cmp (
   input  psd_pkg::edges_type edges,
   output psd_pkg::class_type flags
);

   psd_pkg::prod_type gamma_lo;
   psd_pkg::prod_type gamma_hi;
   psd_pkg::prod_type alpha_lo;
   psd_pkg::prod_type alpha_hi;

   assign gamma_lo = $signed(edges.rhs[psd_pkg::CURVE_GAMMA_LO]);
   assign gamma_hi = $signed(edges.rhs[psd_pkg::CURVE_GAMMA_HI]);
   assign alpha_lo = $signed(edges.rhs[psd_pkg::CURVE_ALPHA_LO]);
   assign alpha_hi = $signed(edges.rhs[psd_pkg::CURVE_ALPHA_HI]);

   // strictly inside, equal is outside
   assign flags.is_gamma = (edges.lhs > gamma_lo) && (edges.lhs < gamma_hi);
   assign flags.is_alpha = (edges.lhs > alpha_lo) && (edges.lhs < alpha_hi);

endmodule

FILE: rtl/core/psd_band_classifier.sv
`timescale 1ns / 1ps
// psd_band_classifier: pulse shape discrimination by piecewise linear bands
// req_chan carries one detector event per transaction (energy with 4 fractional
// bits, prompt_fraction with 14 fractional bits); rsp_chan returns one
// transaction per event with is_gamma and is_alpha, in arrival order.
// Both channels use valid/ready; a transaction moves when both are high.
// Pipeline: input register, interpolation register (segment select and
// cross multiplication by the segment width), result register.
// Throughput is one event per cycle while rsp_chan.ready stays high; the width
// multiply feeding the interpolation register sets the stage delay.
// When rsp_chan.ready is low, the result register holds and earlier stages
// keep filling until all three are full; req_chan.ready then drops.
// Synchronous active-high reset empties all stages; no tables need clearing.
`include "psd_band_classifier_defines.svh"

module psd_band_classifier (
   input  logic         clock,
   input  logic         reset,
   psd_req_if.sink      req_chan,
   psd_rsp_if.source    rsp_chan
);

   logic                                       v1_ff, v1_in;
   logic                                       v2_ff, v2_in;
   logic                                       v3_ff, v3_in;
   logic                                       en1, en2, en3;
   logic signed [psd_pkg::ENERGY_WIDTH-1:0]    energy_ff, energy_in;
   logic signed [psd_pkg::FRACTION_WIDTH-1:0]  frac_ff, frac_in;
   psd_pkg::edges_type                         edges;
   psd_pkg::edges_type                         edges_ff, edges_in;
   psd_pkg::class_type                         flags;
   psd_pkg::class_type                         cls_ff, cls_in;

   assign en3 = !v3_ff || rsp_chan.ready;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;

   assign req_chan.ready = en1;

   assign v1_in     = en1 ? req_chan.valid : v1_ff;
   assign v2_in     = en2 ? v1_ff : v2_ff;
   assign v3_in     = en3 ? v2_ff : v3_ff;
   assign energy_in = en1 ? req_chan.energy : energy_ff;
   assign frac_in   = en1 ? req_chan.prompt_fraction : frac_ff;
   assign edges_in  = en2 ? edges : edges_ff;
   assign cls_in    = en3 ? flags : cls_ff;

   psd_interp u_interp (
      .energy          (energy_ff),
      .prompt_fraction (frac_ff),
      .edges           (edges)
   );

   psd_band_cmp u_cmp (
      .edges (edges_ff),
      .flags (flags)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      energy_ff <= energy_in;
      frac_ff   <= frac_in;
      edges_ff  <= edges_in;
      cls_ff    <= cls_in;
   end

   assign rsp_chan.valid    = v3_ff;
   assign rsp_chan.is_gamma = cls_ff.is_gamma;
   assign rsp_chan.is_alpha = cls_ff.is_alpha;

   `PSD_ASSERT_NEXT(a_accept_fills, clock, reset, req_chan.valid && req_chan.ready, v1_ff)
   `PSD_ASSERT_NEXT(a_stage2_holds, clock, reset, v2_ff && !en3, v2_ff && $stable(edges_ff))
   `PSD_ASSERT_NEXT(a_stage2_moves, clock, reset, v2_ff && en3, rsp_chan.valid)
   `PSD_ASSERT_SAME(a_full_blocks, clock, reset, v1_ff && !en2, !req_chan.ready)

endmodule

FILE: tb/psd_band_classifier_tb.sv
`timescale 1ns / 1ps

module psd_band_classifier_tb;

   localparam int RANDOM_EVENTS = 1050;
   localparam int DIRECTED_EVENTS = 23;
   localparam int CYCLE_LIMIT = 400000;
   localparam int REPORT_LIMIT = 10;

   typedef logic signed [psd_pkg::ENERGY_WIDTH-1:0]   energy_type;
   typedef logic signed [psd_pkg::FRACTION_WIDTH-1:0] fraction_type;

   typedef struct {
      energy_type   energy;
      fraction_type fraction;
      bit           typed;
      bit           want_gamma;
      bit           want_alpha;
   } probe_type;

   typedef struct {
      energy_type         energy;
      fraction_type       fraction;
      psd_pkg::class_type cls;
   } pending_type;

   logic clock;
   logic reset;

   psd_req_if req_chan ();
   psd_rsp_if rsp_chan ();

   psd_band_classifier DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   pending_type pending_classes [$];
   int          fail_count = 0;
   int          cycle_count = 0;
   int          rsp_stall_left = 0;
   int          rsp_cycle = 0;
   bit          rsp_steady = 1'b0;

   // energy, fraction, typed, gamma, alpha
   probe_type directed_probes [DIRECTED_EVENTS] = '{
      '{20'h80000, 16'sd8192, 1'b1, 1'b1, 1'b1},
      '{20'h80000, 16'h8000, 1'b1, 1'b0, 1'b0},
      '{20'h7FFFF, 16'sd4096, 1'b1, 1'b1, 1'b0},
      '{20'h7FFFF, 16'sd8192, 1'b1, 1'b0, 1'b1},
      '{20'h7FFFF, 16'h7FFF, 1'b1, 1'b0, 1'b0},
      '{20'sd0, 16'sd0, 1'b1, 1'b0, 1'b0},
      '{20'sd1600, 16'sd8192, 1'b1, 1'b0, 1'b1},
      '{20'sd400000, 16'sd4096, 1'b1, 1'b1, 1'b0},
      '{20'hFFFFF, 16'sd9000, 1'b1, 1'b1, 1'b1},
      '{20'sd1, 16'sd9830, 1'b0, 1'b0, 1'b0},
      '{20'sd399999, 16'sd5242, 1'b0, 1'b0, 1'b0},
      '{20'sd800, 16'sd9011, 1'b0, 1'b0, 1'b0},
      '{20'sd3200, 16'sd7000, 1'b0, 1'b0, 1'b0},
      '{20'sd4800, 16'sd7373, 1'b0, 1'b0, 1'b0},
      '{20'sd8000, 16'sd6881, 1'b0, 1'b0, 1'b0},
      '{20'sd80000, 16'sd4000, 1'b0, 1'b0, 1'b0},
      '{20'sd160000, 16'sd6554, 1'b0, 1'b0, 1'b0},
      '{20'sd240000, 16'sd13926, 1'b0, 1'b0, 1'b0},
      '{20'sd320000, 16'sd3277, 1'b0, 1'b0, 1'b0},
      '{20'sd1599, 16'sd16383, 1'b0, 1'b0, 1'b0},
      '{20'sd100000, 16'hFFFF, 1'b0, 1'b0, 1'b0},
      '{20'sd200000, 16'h7FFF, 1'b0, 1'b0, 1'b0},
      '{20'h40000, 16'sd15564, 1'b0, 1'b0, 1'b0}
   };

   function automatic longint breakpoint_position(input int k);
      return longint'(psd_pkg::BP_PE[k]) <<< psd_pkg::ENERGY_FRAC_BITS;
   endfunction

   // sign of fraction minus the band edge of curve c
   function automatic int edge_sign(input longint f, input bit interp, input int idx,
                                    input longint t, input longint d, input int c);
      longint lhs;
      longint rhs;
      longint y0;
      longint y1;
      if (!interp) begin
         lhs = f * 100;
         rhs = (longint'(1) <<< psd_pkg::FRACTION_SHIFT) *
               longint'(psd_pkg::EDGE_TAB[c][idx]);
      end else begin
         y0 = psd_pkg::EDGE_TAB[c][idx];
         y1 = psd_pkg::EDGE_TAB[c][idx+1];
         lhs = f * 100 * d;
         rhs = (longint'(1) <<< psd_pkg::FRACTION_SHIFT) * (y0 * d + t * (y1 - y0));
      end
      if (lhs > rhs) return 1;
      if (lhs < rhs) return -1;
      return 0;
   endfunction

   function automatic psd_pkg::class_type classify_event(input energy_type energy,
                                                         input fraction_type fraction);
      longint             e;
      longint             f;
      longint             t;
      longint             d;
      bit                 interp;
      int                 idx;
      psd_pkg::class_type cls;
      e = energy;
      f = fraction;
      t = 0;
      d = 1;
      interp = 1'b0;
      idx = 0;
      if (e <= breakpoint_position(0)) begin
         idx = 0;
      end else if (e >= breakpoint_position(psd_pkg::BREAKPOINTS-1)) begin
         idx = psd_pkg::BREAKPOINTS - 1;
      end else begin
         for (int k = psd_pkg::BREAKPOINTS - 1; k >= 1; k--) begin
            if (e < breakpoint_position(k)) idx = k - 1;
         end
         interp = 1'b1;
         t = e - breakpoint_position(idx);
         d = breakpoint_position(idx + 1) - breakpoint_position(idx);
         if (d <= 0) begin
            t = 0;
            d = 1;
         end
      end
      cls.is_gamma = edge_sign(f, interp, idx, t, d, psd_pkg::CURVE_GAMMA_LO) > 0 &&
                     edge_sign(f, interp, idx, t, d, psd_pkg::CURVE_GAMMA_HI) < 0;
      cls.is_alpha = edge_sign(f, interp, idx, t, d, psd_pkg::CURVE_ALPHA_LO) > 0 &&
                     edge_sign(f, interp, idx, t, d, psd_pkg::CURVE_ALPHA_HI) < 0;
      return cls;
   endfunction

   function automatic int pick_idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   task automatic send_event(input energy_type energy, input fraction_type fraction,
                             input bit typed, input bit want_gamma, input bit want_alpha);
      pending_type p;
      req_chan.valid <= 1'b1;
      req_chan.energy <= energy;
      req_chan.prompt_fraction <= fraction;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      p.energy = energy;
      p.fraction = fraction;
      if (typed) begin
         p.cls.is_gamma = want_gamma;
         p.cls.is_alpha = want_alpha;
      end else begin
         p.cls = classify_event(energy, fraction);
      end
      pending_classes.insert(pending_classes.size(), p);
   endtask

   task automatic idle_sender(input int cycles);
      if (cycles > 0) begin
         req_chan.valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      req_chan.valid <= 1'b0;
      while (pending_classes.size() != 0) @(posedge clock);
   endtask

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("** psd_band_classifier: FAILED **");
         $finish;
      end
   end

   // result side back-pressure
   always @(posedge clock) begin
      rsp_cycle <= rsp_cycle + 1;
      if (rsp_cycle % 200 == 0) rsp_steady <= ($urandom_range(0, 3) == 0);
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (rsp_stall_left > 0) begin
         rsp_stall_left <= rsp_stall_left - 1;
         rsp_chan.ready <= 1'b0;
      end else if (!rsp_steady && $urandom_range(0, 2) == 0) begin
         rsp_stall_left <= pick_idle_length() - 1;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      pending_type p;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_classes.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
               $display("unexpected transaction: gamma=%b alpha=%b",
                        rsp_chan.is_gamma, rsp_chan.is_alpha);
         end else begin
            p = pending_classes.pop_front();
            if (rsp_chan.is_gamma !== p.cls.is_gamma ||
                rsp_chan.is_alpha !== p.cls.is_alpha) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT)
                  $display("mismatch energy=%0d fraction=%0d: exp g=%b a=%b got g=%b a=%b",
                           p.energy, p.fraction, p.cls.is_gamma, p.cls.is_alpha,
                           rsp_chan.is_gamma, rsp_chan.is_alpha);
            end
         end
      end
   end

   initial begin
      energy_type   e;
      fraction_type f;
      int           r;
      int           k;
      int           c;
      bit           sender_steady;
      reset <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.energy <= '0;
      req_chan.prompt_fraction <= '0;
      sender_steady = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_probes[i]) begin
         send_event(directed_probes[i].energy, directed_probes[i].fraction,
                    directed_probes[i].typed, directed_probes[i].want_gamma,
                    directed_probes[i].want_alpha);
         if ($urandom_range(0, 2) == 0) idle_sender(pick_idle_length());
      end
      drain_results();
      @(posedge clock);

      for (int i = 0; i < RANDOM_EVENTS; i++) begin
         if (i % 100 == 0) sender_steady = ($urandom_range(0, 3) == 0);
         if (i == RANDOM_EVENTS / 2) drain_results();
         r = $urandom_range(0, 99);
         if (r < 15) begin
            e = psd_pkg::ENERGY_WIDTH'($urandom);
            f = psd_pkg::FRACTION_WIDTH'($urandom);
         end else if (r < 40) begin
            // close to a breakpoint and a band edge
            k = $urandom_range(0, psd_pkg::BREAKPOINTS - 1);
            c = $urandom_range(0, psd_pkg::CURVES - 1);
            e = psd_pkg::ENERGY_WIDTH'(psd_pkg::BP_PE[k] * (1 << psd_pkg::ENERGY_FRAC_BITS) +
                                       int'($urandom_range(0, 4)) - 2);
            f = psd_pkg::FRACTION_WIDTH'(
                   psd_pkg::EDGE_TAB[c][k] * (1 << psd_pkg::FRACTION_SHIFT) / 100 +
                   int'($urandom_range(0, 4)) - 2);
         end else begin
            e = psd_pkg::ENERGY_WIDTH'(int'($urandom_range(0, 400064)) - 32);
            f = psd_pkg::FRACTION_WIDTH'(int'($urandom_range(0, 17000)) - 300);
         end
         send_event(e, f, 1'b0, 1'b0, 1'b0);
         if (!sender_steady && $urandom_range(0, 2) == 0) idle_sender(pick_idle_length());
      end

      drain_results();
      repeat (16) @(posedge clock);
      if (fail_count == 0) begin
         $display("** psd_band_classifier: PASSED **");
      end else begin
         $display("** psd_band_classifier: FAILED **");
      end
      $finish;
   end

endmodule
